### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PWSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PWSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pwsw_pkg.sv
// shared types and constants of the page walk / set writable block
package pwsw_pkg;

  localparam int MEM_WORDS_DEF = 4096;
  localparam int POS_W         = 49;   // table base (40 bits) joined with 9-bit index
  localparam int TBL_W         = 40;   // physical address bits 51..12
  localparam int VA_W          = 48;
  localparam int WORD_W        = 64;
  localparam int WI_W          = 12;

  localparam int BIT_PRESENT  = 0;
  localparam int BIT_WRITABLE = 1;
  localparam int BIT_HUGE     = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_WALK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_PRESENT  = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SZ_4K = 2'd0,
    SZ_2M = 2'd1,
    SZ_1G = 2'd2
  } size_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [VA_W-1:0]   walk_va;
    logic [WI_W-1:0]   word_index;
    logic [WORD_W-1:0] word_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        fail_level;
    logic [1:0]        leaf_size;
    logic              changed;
    logic [VA_W-1:0]   flush_addr;
    logic [WORD_W-1:0] read_data;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic first;
    logic word_wr;
    logic word_rd;
    logic walk_rd;
    logic set_oor;
    logic set_np;
    logic set_leaf;
    logic wr_back;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic wi_ok;
    logic pos_ok;
    logic present;
    logic leaf;
    logic writable;
  } sts_t;

endpackage

### rtl/pwsw_chan_if.sv
// valid/ready channel carrying one payload type
interface pwsw_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/pwsw_ram.sv
// generic single-port RAM with registered read
module pwsw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/pwsw_dp.sv
// datapath: request registers, root register, table memory, result and output registers
module pwsw_dp #(
  parameter int MEM_WORDS = pwsw_pkg::MEM_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [pwsw_pkg::TBL_W-1:0]       cfg_root,
  input  pwsw_pkg::in_item_t               in_item,
  input  pwsw_pkg::cmd_t                   cmd,
  output pwsw_pkg::sts_t                   sts,
  output pwsw_pkg::out_item_t              out_item
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [pwsw_pkg::TBL_W-1:0]  root_r;
  logic [1:0]                  op_r;
  logic [pwsw_pkg::VA_W-1:0]   va_r;
  logic [pwsw_pkg::WI_W-1:0]   wi_r;
  logic [pwsw_pkg::WORD_W-1:0] wd_r;
  logic [AW-1:0]               pos_r;
  logic [1:0]                  lvl_r;

  logic [1:0]                  res_st_r;
  logic [1:0]                  res_lvl_r;
  logic [1:0]                  res_size_r;
  logic                        res_chg_r;
  logic [pwsw_pkg::VA_W-1:0]   res_flush_r;
  logic                        rd_sel_r;

  pwsw_pkg::out_item_t         out_r;

  logic [1:0]                  cand_lvl;
  logic [pwsw_pkg::TBL_W-1:0]  cand_tbl;
  logic [8:0]                  cand_idx;
  logic [pwsw_pkg::POS_W-1:0]  cand_pos;
  logic [pwsw_pkg::WORD_W-1:0] ram_rdata;
  logic [pwsw_pkg::WORD_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_addr;
  logic                        ram_we;
  logic                        ram_re;
  logic [pwsw_pkg::VA_W-1:0]   flush_val;

  // next table position: base from root on the first level, else from the entry just read
  always_comb begin
    cand_lvl = cmd.first ? 2'd0 : lvl_r + 2'd1;
    cand_tbl = cmd.first ? root_r : ram_rdata[51:12];
    unique case (cand_lvl)
      2'd0:    cand_idx = va_r[47:39];
      2'd1:    cand_idx = va_r[38:30];
      2'd2:    cand_idx = va_r[29:21];
      default: cand_idx = va_r[20:12];
    endcase
    cand_pos = {cand_tbl, cand_idx};
  end

  always_comb begin
    sts.op       = pwsw_pkg::op_t'(op_r);
    sts.wi_ok    = pwsw_pkg::POS_W'(wi_r) < pwsw_pkg::POS_W'(MEM_WORDS);
    sts.pos_ok   = cand_pos < pwsw_pkg::POS_W'(MEM_WORDS);
    sts.present  = ram_rdata[pwsw_pkg::BIT_PRESENT];
    sts.writable = ram_rdata[pwsw_pkg::BIT_WRITABLE];
    sts.leaf     = (lvl_r == 2'd3) ||
                   (((lvl_r == 2'd1) || (lvl_r == 2'd2)) && ram_rdata[pwsw_pkg::BIT_HUGE]);
  end

  always_comb begin
    ram_we = cmd.word_wr | cmd.wr_back;
    ram_re = cmd.word_rd | cmd.walk_rd;
    if (cmd.word_wr || cmd.word_rd) begin
      ram_addr = AW'(wi_r);
    end else if (cmd.walk_rd) begin
      ram_addr = cand_pos[AW-1:0];
    end else begin
      ram_addr = pos_r;
    end
    ram_wdata = cmd.word_wr ? wd_r
                            : (ram_rdata | (pwsw_pkg::WORD_W'(1) << pwsw_pkg::BIT_WRITABLE));
  end

  // flush address: the walk address aligned to the page size of the level at which the leaf was found
  always_comb begin
    unique case (lvl_r)
      2'd1:    flush_val = {va_r[47:30], 30'd0};
      2'd2:    flush_val = {va_r[47:21], 21'd0};
      default: flush_val = {va_r[47:12], 12'd0};
    endcase
  end

  pwsw_ram #(
    .WIDTH (pwsw_pkg::WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0;
    end else if (cfg_valid) begin
      root_r <= cfg_root;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r        <= in_item.operation;
      va_r        <= in_item.walk_va;
      wi_r        <= in_item.word_index;
      wd_r        <= in_item.word_data;
      res_st_r    <= pwsw_pkg::ST_OK;
      res_lvl_r   <= 2'd0;
      res_size_r  <= pwsw_pkg::SZ_4K;
      res_chg_r   <= 1'b0;
      res_flush_r <= '0;
      rd_sel_r    <= 1'b0;
    end else begin
      if (cmd.walk_rd) begin
        pos_r <= cand_pos[AW-1:0];
        lvl_r <= cand_lvl;
      end
      if (cmd.word_rd) begin
        rd_sel_r <= 1'b1;
      end
      if (cmd.set_oor) begin
        res_st_r  <= pwsw_pkg::ST_OUT_OF_RANGE;
        res_lvl_r <= cand_lvl;
      end
      if (cmd.set_np) begin
        res_st_r  <= pwsw_pkg::ST_NOT_PRESENT;
        res_lvl_r <= lvl_r;
      end
      if (cmd.set_leaf) begin
        unique case (lvl_r)
          2'd1:    res_size_r <= pwsw_pkg::SZ_1G;
          2'd2:    res_size_r <= pwsw_pkg::SZ_2M;
          default: res_size_r <= pwsw_pkg::SZ_4K;
        endcase
      end
      if (cmd.wr_back) begin
        res_chg_r   <= 1'b1;
        res_flush_r <= flush_val;
      end
    end
  end

  // output register frees the datapath for the next transaction
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status     <= res_st_r;
      out_r.fail_level <= res_lvl_r;
      out_r.leaf_size  <= res_size_r;
      out_r.changed    <= res_chg_r;
      out_r.flush_addr <= res_flush_r;
      out_r.read_data  <= rd_sel_r ? ram_rdata : '0;
    end
  end

  assign out_item = out_r;

endmodule

### rtl/pwsw_ctrl.sv
// controller: sequences word accesses, table walk levels and write-back
module pwsw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pwsw_pkg::sts_t  sts,
  output pwsw_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_CHECK = 5'b00100,
    S_WRITE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.first = 1'b1;
        state_nxt = S_RESP;
        unique case (sts.op)
          pwsw_pkg::OP_WRITE: begin
            cmd.word_wr = sts.wi_ok;
            cmd.set_oor = !sts.wi_ok;
          end
          pwsw_pkg::OP_READ: begin
            cmd.word_rd = sts.wi_ok;
            cmd.set_oor = !sts.wi_ok;
          end
          pwsw_pkg::OP_WALK: begin
            if (sts.pos_ok) begin
              cmd.walk_rd = 1'b1;
              state_nxt   = S_CHECK;
            end else begin
              cmd.set_oor = 1'b1;
            end
          end
          pwsw_pkg::OP_NOP: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_CHECK: begin
        priority if (!sts.present) begin
          cmd.set_np = 1'b1;
          state_nxt  = S_RESP;
        end else if (sts.leaf) begin
          cmd.set_leaf = 1'b1;
          state_nxt    = sts.writable ? S_RESP : S_WRITE;
        end else if (sts.pos_ok) begin
          // descend: next read issued straight from the entry
          cmd.walk_rd = 1'b1;
        end else begin
          cmd.set_oor = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_WRITE: begin
        cmd.wr_back = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/page_walk_set_writable.sv
// top level of the four-level page walker with writable-bit update
//
// Channels: in_ch takes one transaction per request: a table word write,
// a table word read or a walk of a virtual address that makes the leaf writable.
// out_ch returns exactly one result transaction per request, in order.
// cfg_ch writes the root table address (bits 51..12 kept), always ready;
// the user writes it only while no request is outstanding (not enforced).
// Sequence: a word access or a no-op passes the issue and response states;
// a walk also reads one table level per entry until it finds a leaf, a missing
// entry or an out-of-range position, then writes the entry back if not writable.
// A new request is taken once the previous one has moved to the output
// register; a walk's time is set by the dependent reads of the single
// table memory port, one level per cycle.
// Reset clears the controller, the output valid and the root register;
// table memory contents are undefined until written by software.
// A stalled output holds its result; the walker finishes the next
// request and waits in its response state until the output frees up.
module page_walk_set_writable #(
  parameter int MEM_WORDS = pwsw_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pwsw_chan_if.sink   in_ch,
  pwsw_chan_if.source out_ch,
  pwsw_chan_if.sink   cfg_ch
);

  pwsw_pkg::cmd_t cmd;
  pwsw_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  pwsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pwsw_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_root  (cfg_ch.data[51:12]),
    .in_item   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_ch.data)
  );

endmodule

### rtl/pwsw_checker.sv
// port-level checker for the page walker, bound to the top level
`include "assert_macros.svh"

module pwsw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pwsw_pkg::out_item_t out_data
);

  logic out_stall;
  logic fail_out;
  logic in_acc;
  logic clean_fail;

  assign out_stall  = out_valid && !out_ready;
  assign in_acc     = in_valid && in_ready;
  assign fail_out   = out_valid && (out_data.status != pwsw_pkg::ST_OK);
  assign clean_fail = (out_data.changed == 1'b0) && (out_data.flush_addr == '0) &&
                      (out_data.leaf_size == pwsw_pkg::SZ_4K) && (out_data.read_data == '0);

  `PWSW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data), "stalled result changed")
  `PWSW_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_acc, !in_ready, "request taken while one is in work")
  `PWSW_ASSERT_NOW(a_fail_clean, clk, rst_n, fail_out, clean_fail, "failed transaction carries data")
  `PWSW_ASSERT_NOW(a_flush_only_changed, clk, rst_n, out_valid && !out_data.changed, out_data.flush_addr == '0, "flush address without change")

endmodule

bind page_walk_set_writable pwsw_checker u_pwsw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
